>>> sv/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared operation codes and default widths of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int FUNC_BITS = 3;

  localparam logic [FUNC_BITS-1:0] FUNC_ADD = 3'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_SUB = 3'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_MUL = 3'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_DIV = 3'd3;
  localparam logic [FUNC_BITS-1:0] FUNC_MAG = 3'd4;

endpackage

>>> sv/cau_if.sv
// ----------------------------------------------------------------------------
// cau_req_if / cau_rsp_if
// Valid/ready channels for operand beats and result beats.
// ----------------------------------------------------------------------------
interface cau_req_if
  import cau_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [FUNC_BITS-1:0]        func;
  logic signed [WORD_BITS-1:0] a_real;
  logic signed [WORD_BITS-1:0] a_imag;
  logic signed [WORD_BITS-1:0] b_real;
  logic signed [WORD_BITS-1:0] b_imag;

  modport source (output valid, func, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, func, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_rsp_if
  import cau_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] res_real;
  logic signed [WORD_BITS-1:0] res_imag;
  logic                        overflow;
  logic                        div_zero;

  modport source (output valid, res_real, res_imag, overflow, div_zero, input ready);
  modport sink   (input valid, res_real, res_imag, overflow, div_zero, output ready);
endinterface

>>> sv/complex_arith_unit_core.sv
// ----------------------------------------------------------------------------
// complex_arith_unit_core
// Pipelined complex add, subtract, multiply, divide and magnitude.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one operation per beat: func and operands a, b in signed
//   fixed point (WORD_BITS wide, FRAC_BITS fraction bits). rsp_o returns one
//   result beat per request beat, in order, with saturation and flags.
//   The pipeline has one product stage, one sum stage, one setup stage,
//   WORD_BITS digit stages that produce one quotient bit and one root bit
//   each, and the output register.
//   Throughput is one beat per cycle while rsp_o is not stalled; the digit stages set the depth.
//   All stages advance together; when rsp_o is stalled with a result held,
//   the whole pipeline holds and req_i.ready drops, so nothing is lost.
//   Reset clears every valid bit; the pipeline is empty afterward.
//   Divide by zero returns zero with div_zero set; unused codes return zero.
// ----------------------------------------------------------------------------
module complex_arith_unit_core
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cau_req_if.sink   req_i,
  cau_rsp_if.source rsp_o
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int SW = 2 * W + 2;          // saturation input width
  localparam int XW = 2 * W + 1 + F;      // shifted numerator magnitude
  localparam int CW = 3 * W + F + 1;      // overflow compare width
  localparam int RW = W + 3;              // root remainder width

  localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = ~MAXV;

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic [W-1:0]         fin_re;
    logic [W-1:0]         fin_im;
    logic                 fin_ovf;
    logic                 dz;
    logic                 ovf_re;
    logic                 ovf_im;
    logic                 neg_re;
    logic                 neg_im;
    logic [2*W-1:0]       den;
    logic [2*W-1:0]       rem_re;
    logic [W-1:0]         x_re;
    logic [W-1:0]         q_re;
    logic [2*W-1:0]       rem_im;
    logic [W-1:0]         x_im;
    logic [W-1:0]         q_im;
    logic [2*W-1:0]       s;
    logic [RW-1:0]        srem;
    logic [W-1:0]         root;
  } it_t;

  // saturate a wide signed value: {overflow, word}
  function automatic logic [W:0] sat(input logic signed [SW-1:0] v);
    logic [W:0] r;
    if (v > MAXV) r = {1'b1, MAXV[W-1:0]};
    else if (v < MINV) r = {1'b1, MINV[W-1:0]};
    else r = {1'b0, v[W-1:0]};
    return r;
  endfunction

  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || rsp_o.ready;
  assign req_i.ready = en;

  // Stage 1: products
  logic                   v1_q;
  logic [FUNC_BITS-1:0]   f1_q;
  logic signed [W-1:0]    ar1_q, ai1_q, br1_q, bi1_q;
  logic signed [2*W-1:0]  arbr_q, aibi_q, arbi_q, aibr_q, arar_q, aiai_q, brbr_q, bibi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q   <= req_i.func;
      ar1_q  <= req_i.a_real;
      ai1_q  <= req_i.a_imag;
      br1_q  <= req_i.b_real;
      bi1_q  <= req_i.b_imag;
      arbr_q <= req_i.a_real * req_i.b_real;
      aibi_q <= req_i.a_imag * req_i.b_imag;
      arbi_q <= req_i.a_real * req_i.b_imag;
      aibr_q <= req_i.a_imag * req_i.b_real;
      arar_q <= req_i.a_real * req_i.a_real;
      aiai_q <= req_i.a_imag * req_i.a_imag;
      brbr_q <= req_i.b_real * req_i.b_real;
      bibi_q <= req_i.b_imag * req_i.b_imag;
    end
  end

  // Stage 2: sums of operands and products
  logic                  v2_q;
  logic [FUNC_BITS-1:0]  f2_q;
  logic signed [W:0]     sre_q, sim_q;
  logic signed [2*W:0]   mre_q, mim_q, nre_q, nim_q;
  logic [2*W-1:0]        den_q, sq_q;
  logic signed [2*W:0]   den_w, sq_w;

  assign den_w = (2*W+1)'(brbr_q) + (2*W+1)'(bibi_q);
  assign sq_w  = (2*W+1)'(arar_q) + (2*W+1)'(aiai_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f2_q <= f1_q;
      if (f1_q == FUNC_SUB) begin
        sre_q <= (W+1)'(ar1_q) - (W+1)'(br1_q);
        sim_q <= (W+1)'(ai1_q) - (W+1)'(bi1_q);
      end else begin
        sre_q <= (W+1)'(ar1_q) + (W+1)'(br1_q);
        sim_q <= (W+1)'(ai1_q) + (W+1)'(bi1_q);
      end
      mre_q <= (2*W+1)'(arbr_q) - (2*W+1)'(aibi_q);
      mim_q <= (2*W+1)'(arbi_q) + (2*W+1)'(aibr_q);
      nre_q <= (2*W+1)'(arbr_q) + (2*W+1)'(aibi_q);
      nim_q <= (2*W+1)'(aibr_q) - (2*W+1)'(arbi_q);
      den_q <= den_w[2*W-1:0];
      sq_q  <= sq_w[2*W-1:0];
    end
  end

  // Stage 3: finish add, subtract, multiply; set up divide and root
  logic        vld_q [0:W];
  it_t         st_q  [0:W];
  it_t         st3_d;
  logic [W:0]  sat_re, sat_im;
  logic [2*W:0] mag_re, mag_im;
  logic [XW-1:0] x_re, x_im;
  logic        dz3;

  always_comb begin
    mag_re = nre_q[2*W] ? (2*W+1)'(-nre_q) : nre_q;
    mag_im = nim_q[2*W] ? (2*W+1)'(-nim_q) : nim_q;
    x_re   = XW'(mag_re) << F;
    x_im   = XW'(mag_im) << F;
    dz3    = (den_q == '0);
    sat_re = '0;
    sat_im = '0;
    unique case (f2_q)
      FUNC_ADD, FUNC_SUB: begin
        sat_re = sat(SW'(sre_q));
        sat_im = sat(SW'(sim_q));
      end
      FUNC_MUL: begin
        sat_re = sat(SW'(mre_q >>> F));
        sat_im = sat(SW'(mim_q >>> F));
      end
      default: begin
        sat_re = '0;
        sat_im = '0;
      end
    endcase
    st3_d.func    = f2_q;
    st3_d.fin_re  = sat_re[W-1:0];
    st3_d.fin_im  = sat_im[W-1:0];
    st3_d.fin_ovf = sat_re[W] | sat_im[W];
    st3_d.dz      = (f2_q == FUNC_DIV) && dz3;
    st3_d.ovf_re  = CW'(x_re) >= (CW'(den_q) << W);
    st3_d.ovf_im  = CW'(x_im) >= (CW'(den_q) << W);
    st3_d.neg_re  = nre_q[2*W];
    st3_d.neg_im  = nim_q[2*W];
    st3_d.den     = den_q;
    st3_d.rem_re  = (2*W)'(x_re >> W);
    st3_d.x_re    = x_re[W-1:0];
    st3_d.q_re    = '0;
    st3_d.rem_im  = (2*W)'(x_im >> W);
    st3_d.x_im    = x_im[W-1:0];
    st3_d.q_im    = '0;
    st3_d.s       = sq_q;
    st3_d.srem    = '0;
    st3_d.root    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= st3_d;
    end
  end

  // Digit stages: one quotient bit per divider and one root bit each
  for (genvar k = 0; k < W; k++) begin : g_digit
    it_t            nx;
    logic [2*W:0]   r2_re, r2_im;
    logic [RW-1:0]  sr2, trial;

    always_comb begin
      nx    = st_q[k];
      r2_re = {st_q[k].rem_re, st_q[k].x_re[W-1]};
      r2_im = {st_q[k].rem_im, st_q[k].x_im[W-1]};
      nx.x_re = st_q[k].x_re << 1;
      nx.x_im = st_q[k].x_im << 1;
      if (r2_re >= {1'b0, st_q[k].den}) begin
        nx.rem_re = (2*W)'(r2_re - {1'b0, st_q[k].den});
        nx.q_re   = {st_q[k].q_re[W-2:0], 1'b1};
      end else begin
        nx.rem_re = r2_re[2*W-1:0];
        nx.q_re   = {st_q[k].q_re[W-2:0], 1'b0};
      end
      if (r2_im >= {1'b0, st_q[k].den}) begin
        nx.rem_im = (2*W)'(r2_im - {1'b0, st_q[k].den});
        nx.q_im   = {st_q[k].q_im[W-2:0], 1'b1};
      end else begin
        nx.rem_im = r2_im[2*W-1:0];
        nx.q_im   = {st_q[k].q_im[W-2:0], 1'b0};
      end
      sr2   = {st_q[k].srem[RW-3:0], st_q[k].s[2*W-1:2*W-2]};
      trial = {1'b0, st_q[k].root, 2'b01};
      nx.s  = st_q[k].s << 2;
      if (sr2 >= trial) begin
        nx.srem = sr2 - trial;
        nx.root = {st_q[k].root[W-2:0], 1'b1};
      end else begin
        nx.srem = sr2;
        nx.root = {st_q[k].root[W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[k+1] <= nx;
      end
    end
  end

  // Output stage: sign and saturate quotients, pick the result
  it_t         fs;
  logic [W:0]  dq_re, dq_im, rt;
  logic [W-1:0] res_re_d, res_im_d;
  logic        ovf_d, dz_d;
  logic [W-1:0] res_re_q, res_im_q;
  logic        ovf_q, dz_q;

  always_comb begin
    fs = st_q[W];
    if (fs.ovf_re) dq_re = {1'b1, fs.neg_re ? MINV[W-1:0] : MAXV[W-1:0]};
    else dq_re = sat(fs.neg_re ? -SW'(fs.q_re) : SW'(fs.q_re));
    if (fs.ovf_im) dq_im = {1'b1, fs.neg_im ? MINV[W-1:0] : MAXV[W-1:0]};
    else dq_im = sat(fs.neg_im ? -SW'(fs.q_im) : SW'(fs.q_im));
    rt = sat(SW'(fs.root));
    res_re_d = fs.fin_re;
    res_im_d = fs.fin_im;
    ovf_d    = fs.fin_ovf;
    dz_d     = fs.dz;
    unique case (fs.func)
      FUNC_DIV: begin
        if (fs.dz) begin
          res_re_d = '0;
          res_im_d = '0;
          ovf_d    = 1'b0;
        end else begin
          res_re_d = dq_re[W-1:0];
          res_im_d = dq_im[W-1:0];
          ovf_d    = dq_re[W] | dq_im[W];
        end
      end
      FUNC_MAG: begin
        res_re_d = rt[W-1:0];
        res_im_d = '0;
        ovf_d    = rt[W];
      end
      default: begin
        res_re_d = fs.fin_re;
        res_im_d = fs.fin_im;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      ovf_q    <= ovf_d;
      dz_q     <= dz_d;
    end
  end

  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.res_real = res_re_q;
  assign rsp_o.res_imag = res_im_q;
  assign rsp_o.overflow = ovf_q;
  assign rsp_o.div_zero = dz_q;

endmodule

>>> sim/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker
// Watches the operand and result channels of the complex arithmetic unit,
// computes the expected result of every accepted operand beat and compares
// each result beat against the oldest pending expectation.
// ----------------------------------------------------------------------------
module cau_checker
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  cau_req_if.sink req_i,
  cau_rsp_if.sink rsp_i,
  output int      n_fail_o,
  output int      n_pending_o,
  output int      n_results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] re;
    logic signed [WORD_BITS-1:0] im;
    logic                        ovf;
    logic                        dz;
  } cplx_res_t;

  localparam int WIDE = 4 * WORD_BITS + 8;

  cplx_res_t cplx_expected_q[$];

  // Clamp a wide signed value to the word range, flag when clamped.
  function automatic logic signed [WORD_BITS-1:0] clamp_word(
      input logic signed [WIDE-1:0] v, inout logic ovf);
    logic signed [WIDE-1:0] hi_lim;
    logic signed [WIDE-1:0] lo_lim;
    hi_lim = (WIDE'(1) <<< (WORD_BITS - 1)) - 1;
    lo_lim = -(WIDE'(1) <<< (WORD_BITS - 1));
    if (v > hi_lim) begin
      ovf = 1'b1;
      return hi_lim[WORD_BITS-1:0];
    end
    if (v < lo_lim) begin
      ovf = 1'b1;
      return lo_lim[WORD_BITS-1:0];
    end
    return v[WORD_BITS-1:0];
  endfunction

  // Divide truncating toward zero.
  function automatic logic signed [WIDE-1:0] quot_trunc(
      input logic signed [WIDE-1:0] n, input logic signed [WIDE-1:0] d);
    logic [WIDE-1:0] mag;
    mag = (n < 0 ? -n : n) / d;
    return n < 0 ? -$signed(mag) : $signed(mag);
  endfunction

  // Floor of the square root, bit by bit; the root of a sum of two squared
  // words stays below 2^WORD_BITS.
  function automatic logic signed [WIDE-1:0] root_floor(input logic [WIDE-1:0] s);
    logic [WIDE-1:0] r;
    logic [WIDE-1:0] t;
    r = '0;
    for (int b = WORD_BITS; b >= 0; b--) begin
      t = r | (WIDE'(1) << b);
      if (t * t <= s) r = t;
    end
    return $signed(r);
  endfunction

  function automatic cplx_res_t cplx_compute(
      input logic [FUNC_BITS-1:0] fn,
      input logic signed [WORD_BITS-1:0] ar_w, ai_w, br_w, bi_w);
    logic signed [WIDE-1:0] ar, ai, br, bi, re, im, den;
    cplx_res_t r;
    ar = ar_w; ai = ai_w; br = br_w; bi = bi_w;
    r = '0;
    re = '0;
    im = '0;
    case (fn)
      FUNC_ADD: begin
        re = ar + br; im = ai + bi;
      end
      FUNC_SUB: begin
        re = ar - br; im = ai - bi;
      end
      FUNC_MUL: begin
        re = (ar * br - ai * bi) >>> FRAC_BITS;
        im = (ar * bi + ai * br) >>> FRAC_BITS;
      end
      FUNC_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.dz = 1'b1;
        else begin
          re = quot_trunc((ar * br + ai * bi) <<< FRAC_BITS, den);
          im = quot_trunc((ai * br - ar * bi) <<< FRAC_BITS, den);
        end
      end
      FUNC_MAG: re = root_floor(ar * ar + ai * ai);
      default: ;
    endcase
    r.re = clamp_word(re, r.ovf);
    r.im = clamp_word(im, r.ovf);
    return r;
  endfunction

  // Predict on every operand beat, compare on every result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    cplx_res_t exp_r;
    if (!rst_ni) begin
      n_fail_o    <= 0;
      n_results_o <= 0;
    end else begin
      if (req_i.valid && req_i.ready)
        cplx_expected_q.push_back(cplx_compute(req_i.func, req_i.a_real, req_i.a_imag,
                                               req_i.b_real, req_i.b_imag));
      if (rsp_i.valid && rsp_i.ready) begin
        n_results_o <= n_results_o + 1;
        if (cplx_expected_q.size() == 0) begin
          if (n_fail_o < 10) $display("ERROR: result beat with nothing pending");
          n_fail_o <= n_fail_o + 1;
        end else begin
          exp_r = cplx_expected_q.pop_front();
          if (rsp_i.res_real !== exp_r.re || rsp_i.res_imag !== exp_r.im ||
              rsp_i.overflow !== exp_r.ovf || rsp_i.div_zero !== exp_r.dz) begin
            if (n_fail_o < 10)
              $display("ERROR: got re=%h im=%h ovf=%b dz=%b, expected re=%h im=%h ovf=%b dz=%b",
                       rsp_i.res_real, rsp_i.res_imag, rsp_i.overflow, rsp_i.div_zero,
                       exp_r.re, exp_r.im, exp_r.ovf, exp_r.dz);
            n_fail_o <= n_fail_o + 1;
          end
        end
      end
    end
  end

  assign n_pending_o = cplx_expected_q.size();

endmodule

>>> sim/complex_arith_unit_core_tb.sv
// ----------------------------------------------------------------------------
// complex_arith_unit_core_tb
// Drives directed corner operands and random operations into the complex
// arithmetic unit with bursty input and a stalling output; the checker
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module complex_arith_unit_core_tb;
  import cau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  N_RANDOM    = 1830;
  localparam int  LATENCY     = WORD_BITS_DEF + 4;
  localparam int  CYCLE_LIMIT = 400000;

  typedef logic signed [WORD_BITS_DEF-1:0] word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycle_cnt = 0;
  int   n_fail, n_pending, n_results;
  bit   hold_off = 1'b0;
  int   n_sent = 0;

  cau_req_if req_if ();
  cau_rsp_if rsp_if ();

  complex_arith_unit_core dut (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if), .rsp_o(rsp_if));

  cau_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if), .rsp_i(rsp_if),
    .n_fail_o(n_fail), .n_pending_o(n_pending), .n_results_o(n_results)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    req_if.valid  = 1'b0;
    req_if.func   = FUNC_ADD;
    req_if.a_real = '0;
    req_if.a_imag = '0;
    req_if.b_real = '0;
    req_if.b_imag = '0;
    rsp_if.ready  = 1'b0;
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stall the result side on its own pattern; one long hold-off early on.
  initial begin
    int mode;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) rsp_if.ready <= 1'b0;
      else begin
        mode = (cycle_cnt / 300) % 3;
        rsp_if.ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) != 0 || mode == 2 &&
                                              $urandom_range(0, 1) == 0);
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    repeat (60) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
  end

  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return word_t'($urandom_range(0, 1) ? 32'sh00010000 : 32'shffff0000);
      4, 5: return word_t'($signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
      default: return word_t'($urandom);
    endcase
  endfunction

  // Offer one beat, hold it until accepted.
  task automatic send_op(input logic [FUNC_BITS-1:0] fn, input word_t ar, ai, br, bi);
    req_if.valid  <= 1'b1;
    req_if.func   <= fn;
    req_if.a_real <= ar;
    req_if.a_imag <= ai;
    req_if.b_real <= br;
    req_if.b_imag <= bi;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic go_idle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    word_t mx, mn;
    int burst;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corners: extremes, every code, zero divisor, unused codes.
    send_op(FUNC_ADD, mx, mn, mx, mn);
    send_op(FUNC_ADD, mn, mx, mn, mx);
    send_op(FUNC_SUB, mx, mn, mn, mx);
    send_op(FUNC_SUB, 32'sh00010000, 32'sh00020000, 32'sh00030000, -32'sh00010000);
    send_op(FUNC_MUL, mx, mx, mx, mx);
    send_op(FUNC_MUL, mn, mn, mn, mn);
    send_op(FUNC_MUL, -32'sh00000001, 32'sh00000001, 32'sh00000001, 32'sh00000001);
    send_op(FUNC_MUL, 32'sh00018000, -32'sh00008000, 32'sh00020000, 32'sh00010000);
    send_op(FUNC_DIV, 32'sh00010000, 32'sh00010000, '0, '0);
    send_op(FUNC_DIV, mx, mn, '0, '0);
    send_op(FUNC_DIV, 32'sh00010000, '0, 32'sh00000001, '0);
    send_op(FUNC_DIV, mn, mn, 32'sh00000001, 32'sh00000001);
    send_op(FUNC_DIV, -32'sh00030000, 32'sh00010000, 32'sh00020000, -32'sh00010000);
    send_op(FUNC_DIV, mx, mx, mn, mn);
    send_op(FUNC_MAG, mn, mn, '0, '0);
    send_op(FUNC_MAG, mx, '0, '0, '0);
    send_op(FUNC_MAG, 32'sh00030000, 32'sh00040000, '0, '0);
    send_op(FUNC_MAG, '0, '0, '0, '0);
    send_op(3'd5, mx, mx, mx, mx);
    send_op(3'd6, mn, mn, mn, mn);
    send_op(3'd7, 32'sh1234, 32'sh5678, 32'sh9abc, 32'shdef0);
    go_idle();

    // Random bursts; one or more drains partway through.
    while (n_sent < 21 + N_RANDOM) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst; i++)
        send_op(($urandom_range(0, 9) == 0) ? FUNC_BITS'($urandom_range(5, 7))
                  : FUNC_BITS'($urandom_range(0, 4)),
                pick_word(), pick_word(), pick_word(), pick_word());
      if (n_sent > 900 && n_sent < 945) begin
        go_idle();
        while (n_pending != 0) @(posedge clk_i);
      end else if ($urandom_range(0, 3) != 0) begin
        req_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    go_idle();

    while (n_pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("Sent %0d operations over all codes, corners and zero divisors; %0d results",
             n_sent, n_results);
    if (n_fail == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
